[rtl/bfns_pkg.sv]
// Package for the bit table find-next-set block.
// Holds request kinds, sequencer states and fixed field widths; no dependencies.
package bfns_pkg;

    // Width of a bit position and of the request kind
    localparam int POS_W  = 12;
    localparam int KIND_W = 2;

    // Fixed-point shift used when splitting a position into word and bit
    localparam int MUL_S  = 20;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SET   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_WIPE  = 2'd2,
        KIND_FIND  = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_DISPATCH,
        ST_SET_WR,
        ST_CLR_WR,
        ST_WIPE,
        ST_FIND
    } state_t;

endpackage

[rtl/bfns_store.sv]
// Word store of the bit table: one write port, one registered read port.
// Depends on nothing but its parameters.
module bfns_store #(
    parameter int WORD_COUNT = 64,
    parameter int WORD_BITS  = 64,
    parameter int ADDR_W     = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bfns_scan.sv]
// Lowest set bit at or above a start bit within one stored word.
// Depends on nothing but its parameters.
module bfns_scan #(
    parameter int WORD_BITS = 64,
    parameter int BIT_W     = 6
) (
    input  logic [WORD_BITS-1:0] word_data,
    input  logic [BIT_W-1:0]     from_bit,
    output logic                 hit,
    output logic [BIT_W-1:0]     hit_bit
);

    // Priority encode from the top down so the lowest qualifying bit wins
    always_comb
    begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (word_data[i] && (BIT_W'(i) >= from_bit))
            begin
                hit     = 1'b1;
                hit_bit = BIT_W'(i);
            end
        end
    end

endmodule

[rtl/bitset_find_next_set.sv]
// Top level of the bit table find-next-set block: sequencer and position split.
// Depends on bfns_pkg, bfns_store and bfns_scan.
//
// Usage:
//   A transaction is taken when start is high and busy is low; kind and
//   position are sampled then. Kinds: set bit, clear bit, clear all, find
//   the lowest set bit at or above position. Every transaction gives one
//   result, shown for one cycle with done high: found, found_index and
//   out_of_range. Fields that do not apply to the kind read zero.
//   After acceptance: split, dispatch, then by kind:
//     set, clear : word rewritten (not for a set out of range or clear past used words)
//     find       : word scan from position upward (none when past used words)
//     clear all  : wipe of the used words (none when the table is empty)
//   A find walks the used words one per cycle through the single read port
//   of the word store; a clear-all writes zero to one used word per cycle.
//   busy is high from acceptance until done; the next one can be taken as done ends.
//   After reset the store is swept to zero, one word per cycle, so busy
//   stays high until all WORD_COUNT words are zero, before the first transaction.
//   The receiver cannot stall: done is a one-cycle strobe.
module bitset_find_next_set #(
    parameter int WORD_COUNT = 64,
    parameter int WORD_BITS  = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bfns_pkg::kind_t               kind,
    input  logic [bfns_pkg::POS_W-1:0]    position,
    output logic                          done,
    output logic                          found,
    output logic [bfns_pkg::POS_W-1:0]    found_index,
    output logic                          out_of_range
);

    import bfns_pkg::*;

    localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int USED_W = $clog2(WORD_COUNT + 1);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int CMP_W  = POS_W + 1;
    localparam int PROD_W = POS_W + MUL_S;
    localparam int MW     = POS_W + 8;
    localparam int RECIP  = (1 << MUL_S) / WORD_BITS;

    // Registers
    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [POS_W-1:0]    word_reg, word_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [POS_W-1:0]    base_reg, base_next;
    logic [ADDR_W-1:0]   scan_addr_reg, scan_addr_next;
    logic                first_reg, first_next;
    logic [ADDR_W-1:0]   wipe_addr_reg, wipe_addr_next;
    logic                init_reg, init_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic                done_reg, done_next;
    logic                found_reg, found_next;
    logic [POS_W-1:0]    found_index_reg, found_index_next;
    logic                oor_reg, oor_next;

    // Store and scanner hookup
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic [BIT_W-1:0]     scan_from;
    logic                 scan_hit;
    logic [BIT_W-1:0]     scan_bit;

    // Position split helpers
    logic [POS_W-1:0]     q0;
    logic [MW-1:0]        q_times_w;
    logic [MW-1:0]        rem0;
    logic [MW-1:0]        rem_fix;
    logic [CMP_W-1:0]     word_ext;
    logic [CMP_W-1:0]     used_ext;
    logic [CMP_W-1:0]     wipe_last;
    logic [WORD_BITS-1:0] bit_mask;

    bfns_store #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_BITS  (WORD_BITS),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bfns_scan #(
        .WORD_BITS (WORD_BITS),
        .BIT_W     (BIT_W)
    ) u_scan (
        .word_data (rd_data),
        .from_bit  (scan_from),
        .hit       (scan_hit),
        .hit_bit   (scan_bit)
    );

    // Quotient estimate from the registered reciprocal product, then one correction
    always_comb
    begin
        q0        = prod_reg[MUL_S +: POS_W];
        q_times_w = MW'(q0) * MW'(WORD_BITS);
        rem0      = MW'(pos_reg) - q_times_w;
        rem_fix   = rem0 - MW'(WORD_BITS);
    end

    assign word_ext  = CMP_W'(word_reg);
    assign used_ext  = CMP_W'(used_reg);
    assign wipe_last = init_reg ? CMP_W'(WORD_COUNT - 1) : (used_ext - CMP_W'(1));
    assign bit_mask  = WORD_BITS'(1) << bit_reg;
    assign scan_from = first_reg ? bit_reg : '0;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            init_reg      <= 1'b1;
            wipe_addr_reg <= '0;
            used_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            wipe_addr_reg <= wipe_addr_next;
            used_reg      <= used_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        pos_reg         <= pos_next;
        prod_reg        <= prod_next;
        word_reg        <= word_next;
        bit_reg         <= bit_next;
        base_reg        <= base_next;
        scan_addr_reg   <= scan_addr_next;
        first_reg       <= first_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
        oor_reg         <= oor_next;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        pos_next         = pos_reg;
        prod_next        = prod_reg;
        word_next        = word_reg;
        bit_next         = bit_reg;
        base_next        = base_reg;
        scan_addr_next   = scan_addr_reg;
        first_next       = first_reg;
        wipe_addr_next   = wipe_addr_reg;
        init_next        = init_reg;
        used_next        = used_reg;
        done_next        = 1'b0;
        found_next       = found_reg;
        found_index_next = found_index_reg;
        oor_next         = oor_reg;
        wr_en            = 1'b0;
        wr_addr          = word_reg[ADDR_W-1:0];
        wr_data          = rd_data;
        rd_addr          = word_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    pos_next   = position;
                    prod_next  = PROD_W'(position) * PROD_W'(RECIP);
                    state_next = ST_SPLIT;
                end
            end

            // Word index, bit offset and bit index of the word's first bit
            ST_SPLIT:
            begin
                if (rem0 >= MW'(WORD_BITS))
                begin
                    word_next = q0 + POS_W'(1);
                    bit_next  = BIT_W'(rem_fix);
                    base_next = pos_reg - POS_W'(rem_fix);
                end
                else
                begin
                    word_next = q0;
                    bit_next  = BIT_W'(rem0);
                    base_next = pos_reg - POS_W'(rem0);
                end
                state_next = ST_DISPATCH;
            end

            ST_DISPATCH:
            begin
                found_next       = 1'b0;
                found_index_next = '0;
                oor_next         = 1'b0;
                unique case (kind_reg)
                    KIND_SET:
                    begin
                        if (word_ext >= CMP_W'(WORD_COUNT))
                        begin
                            oor_next   = 1'b1;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_SET_WR;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        if (word_ext < used_ext)
                        begin
                            state_next = ST_CLR_WR;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_WIPE:
                    begin
                        wipe_addr_next = '0;
                        if (used_reg == '0)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_WIPE;
                        end
                    end
                    KIND_FIND:
                    begin
                        scan_addr_next = word_reg[ADDR_W-1:0];
                        first_next     = 1'b1;
                        if (word_ext < used_ext)
                        begin
                            state_next = ST_FIND;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // Read-modify-write of one word
            ST_SET_WR:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data | bit_mask;
                if (word_ext >= used_ext)
                begin
                    used_next = USED_W'(word_ext + CMP_W'(1));
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_CLR_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data & ~bit_mask;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            // Zero one word a cycle: whole store after reset, used words on clear-all
            ST_WIPE:
            begin
                wr_en   = 1'b1;
                wr_addr = wipe_addr_reg;
                wr_data = '0;
                if (CMP_W'(wipe_addr_reg) == wipe_last)
                begin
                    used_next  = '0;
                    done_next  = !init_reg;
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    wipe_addr_next = wipe_addr_reg + ADDR_W'(1);
                end
            end

            // One stored word per cycle through the scanner
            ST_FIND:
            begin
                rd_addr = scan_addr_reg + ADDR_W'(1);
                if (scan_hit)
                begin
                    found_next       = 1'b1;
                    found_index_next = base_reg + POS_W'(scan_bit);
                    done_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
                else if ((CMP_W'(scan_addr_reg) + CMP_W'(1)) >= used_ext)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + ADDR_W'(1);
                    base_next      = base_reg + POS_W'(WORD_BITS);
                    first_next     = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign found        = found_reg;
    assign found_index  = found_index_reg;
    assign out_of_range = oor_reg;

endmodule
